@@ design/gcr_pkg.sv @@
// shared constants and types for the graph column rasterizer
package gcr_pkg;

  localparam int PAGES      = 7;
  localparam int PAGE_W     = 3;
  localparam int ROW_W      = PAGE_W + 3;
  localparam int SAMPLE_W   = 16;
  localparam int QUO_W      = 6;
  localparam int DIV_STEPS  = QUO_W;
  localparam int SHIFT_W    = 3;
  localparam int NUM_W      = SAMPLE_W + QUO_W;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;

  localparam logic [ROW_W-1:0]   LAST_ROW   = ROW_W'(55);
  localparam logic [PAGE_W-1:0]  LAST_PAGE  = PAGE_W'(PAGES - 1);
  localparam logic [SHIFT_W-1:0] LAST_SHIFT = SHIFT_W'(DIV_STEPS - 1);

  localparam logic [7:0] CURSOR_SHADE = 8'h55;
  localparam logic [7:0] TOP_KEEP     = 8'hC0;
  localparam logic [7:0] BOT_KEEP     = 8'h03;
  localparam logic [7:0] FULL_KEEP    = 8'hFF;

  // register index, taken from paddr[3:2]
  localparam logic [1:0] REG_RANGE_LOW    = 2'd0;
  localparam logic [1:0] REG_RANGE_HIGH   = 2'd1;
  localparam logic [1:0] REG_POINTS_ONLY  = 2'd2;
  localparam logic [1:0] REG_CURSOR_SHOWN = 2'd3;

  localparam logic [15:0] RANGE_LOW_RST  = 16'd0;
  localparam logic [15:0] RANGE_HIGH_RST = 16'd55;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] range_low;
    logic signed [SAMPLE_W-1:0] range_high;
    logic                       points_only;
    logic                       cursor_shown;
  } gcr_cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_value;
    logic                       sample_filled;
    logic                       column_is_cursor;
    logic [7:0]                 top_label_byte;
    logic                       top_label_on;
    logic [7:0]                 bottom_label_byte;
    logic                       bottom_label_on;
  } gcr_item_t;

  typedef struct packed {
    logic               load;
    logic               prep;
    logic               div_step;
    logic [SHIFT_W-1:0] div_shift;
    logic               commit;
    logic [PAGE_W-1:0]  page;
  } gcr_cmd_t;

endpackage

@@ design/graph_column_rasterizer_top.sv @@
// Graph column rasterizer: one sample in per column, seven page bytes out.
// Input stream: one transaction per graph column. tdata carries the sample,
// cursor flag and both label glyphs; tuser says whether the sample is real.
// Output stream: PAGES transactions per column, page 0 first. tdata is the
// page byte (bit 0 = top row), tuser the page number, tlast marks the last
// page of the column.
// APB port: range_low at 0x0, range_high at 0x4, points_only at 0x8,
// cursor_shown at 0xC; write only while no column is in flight.
// Timing: a column passes through accept, scale, 6 divider steps, commit and
// then the 7 page bytes, which wait while the receiver stalls. The seven page
// bytes and the divider, one quotient bit per cycle, set most of the time a
// column takes.
// One column is in flight at a time: tready is low from acceptance until
// the last page byte has been taken. A stalled receiver simply holds the
// current page byte and its valid.
// Reset clears the sequencer, the previous point and the registers to
// range 0..55, line mode, no cursor shading.
module graph_column_rasterizer_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // [15:0] sample_value, [16] column_is_cursor, [24:17] top_label_byte,
  // [25] top_label_on, [33:26] bottom_label_byte, [34] bottom_label_on
  input  logic [39:0]                 s_axis_tdata_i,
  // [0] sample_filled
  input  logic                        s_axis_tuser_i,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // [7:0] page_byte
  output logic [7:0]                  m_axis_tdata_o,
  // [2:0] page_index
  output logic [gcr_pkg::PAGE_W-1:0]  m_axis_tuser_o,
  output logic                        m_axis_tlast_o,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [gcr_pkg::ADDR_W-1:0]  paddr_i,
  input  logic [gcr_pkg::DATA_W-1:0]  pwdata_i,
  output logic [gcr_pkg::DATA_W-1:0]  prdata_o,
  output logic                        pready_o
);
  import gcr_pkg::*;

  gcr_cfg_t  cfg_q;
  gcr_item_t item;
  gcr_cmd_t  cmd;
  logic      cfg_wr;
  logic [1:0] reg_idx;

  assign pready_o = 1'b1;
  assign reg_idx  = paddr_i[3:2];
  assign cfg_wr   = psel_i && penable_i && pwrite_i && pready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.range_low    <= RANGE_LOW_RST;
      cfg_q.range_high   <= RANGE_HIGH_RST;
      cfg_q.points_only  <= 1'b0;
      cfg_q.cursor_shown <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_RANGE_LOW:    cfg_q.range_low    <= pwdata_i[SAMPLE_W-1:0];
        REG_RANGE_HIGH:   cfg_q.range_high   <= pwdata_i[SAMPLE_W-1:0];
        REG_POINTS_ONLY:  cfg_q.points_only  <= pwdata_i[0];
        REG_CURSOR_SHOWN: cfg_q.cursor_shown <= pwdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_RANGE_LOW:    prdata_o = DATA_W'(cfg_q.range_low);
      REG_RANGE_HIGH:   prdata_o = DATA_W'(cfg_q.range_high);
      REG_POINTS_ONLY:  prdata_o = DATA_W'(cfg_q.points_only);
      REG_CURSOR_SHOWN: prdata_o = DATA_W'(cfg_q.cursor_shown);
      default:          prdata_o = '0;
    endcase
  end

  always_comb begin
    item.sample_value      = s_axis_tdata_i[15:0];
    item.sample_filled     = s_axis_tuser_i;
    item.column_is_cursor  = s_axis_tdata_i[16];
    item.top_label_byte    = s_axis_tdata_i[24:17];
    item.top_label_on      = s_axis_tdata_i[25];
    item.bottom_label_byte = s_axis_tdata_i[33:26];
    item.bottom_label_on   = s_axis_tdata_i[34];
  end

  gcr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_last_o  (m_axis_tlast_o),
    .cmd_o       (cmd)
  );

  gcr_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .item_i      (item),
    .cfg_i       (cfg_q),
    .page_byte_o (m_axis_tdata_o)
  );

  assign m_axis_tuser_o = cmd.page;

endmodule

@@ design/gcr_datapath.sv @@
// sample scaling, serial divider, point and line state, page byte forming
module gcr_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gcr_pkg::gcr_cmd_t  cmd_i,
  input  gcr_pkg::gcr_item_t item_i,
  input  gcr_pkg::gcr_cfg_t  cfg_i,
  output logic [7:0]         page_byte_o
);
  import gcr_pkg::*;

  gcr_item_t              item_q;
  logic                   in_range_q, in_range_d;
  logic [NUM_W-1:0]       rem_q;
  logic [SAMPLE_W-1:0]    span_q;
  logic [QUO_W-1:0]       quo_q;
  logic [ROW_W-1:0]       lo_row_q, hi_row_q;
  logic                   lit_q;
  logic [ROW_W-1:0]       prev_row_q;
  logic                   prev_valid_q;

  logic signed [SAMPLE_W:0] diff_s, span_s;
  logic [NUM_W-1:0]         num;
  logic [NUM_W-1:0]         trial;
  logic [ROW_W-1:0]         row;
  logic                     join_run;
  logic [7:0]               pix, keep, extra;
  logic [ROW_W-1:0]         r_idx [8];

  assign diff_s = $signed({item_q.sample_value[SAMPLE_W-1], item_q.sample_value})
                - $signed({cfg_i.range_low[SAMPLE_W-1], cfg_i.range_low});
  assign span_s = $signed({cfg_i.range_high[SAMPLE_W-1], cfg_i.range_high})
                - $signed({cfg_i.range_low[SAMPLE_W-1], cfg_i.range_low});

  assign in_range_d = item_q.sample_filled && (span_s > 0) && (diff_s >= 0)
                    && (item_q.sample_value <= cfg_i.range_high);

  assign num   = NUM_W'(diff_s[SAMPLE_W-1:0]) * NUM_W'(LAST_ROW);
  assign trial = NUM_W'(span_q) << cmd_i.div_shift;

  assign row      = LAST_ROW - ROW_W'(quo_q);
  assign join_run = prev_valid_q && !cfg_i.points_only && (prev_row_q != row);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
    if (cmd_i.prep) begin
      rem_q  <= num;
      span_q <= span_s[SAMPLE_W-1:0];
      quo_q  <= '0;
    end else if (cmd_i.div_step) begin
      // restoring step: quotient does not exceed the last row for an in-range sample
      if (rem_q >= trial) begin
        rem_q                  <= rem_q - trial;
        quo_q[cmd_i.div_shift] <= 1'b1;
      end
    end
    if (cmd_i.commit) begin
      if (join_run) begin
        lo_row_q <= (prev_row_q < row) ? prev_row_q : row;
        hi_row_q <= (prev_row_q < row) ? row : prev_row_q;
      end else begin
        lo_row_q <= row;
        hi_row_q <= row;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_range_q   <= 1'b0;
      lit_q        <= 1'b0;
      prev_row_q   <= '0;
      prev_valid_q <= 1'b0;
    end else begin
      if (cmd_i.prep) begin
        in_range_q <= in_range_d;
      end
      if (cmd_i.commit) begin
        lit_q        <= in_range_q;
        prev_valid_q <= in_range_q;
        if (in_range_q) begin
          prev_row_q <= row;
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      r_idx[k] = {cmd_i.page, 3'(k)};
      pix[k]   = lit_q && (r_idx[k] >= lo_row_q) && (r_idx[k] <= hi_row_q);
    end
    keep  = FULL_KEEP;
    extra = (cfg_i.cursor_shown && item_q.column_is_cursor) ? CURSOR_SHADE : 8'h00;
    if (!cfg_i.cursor_shown) begin
      if (cmd_i.page == '0 && item_q.top_label_on) begin
        keep  = keep & TOP_KEEP;
        extra = extra | item_q.top_label_byte;
      end
      if (cmd_i.page == LAST_PAGE && item_q.bottom_label_on) begin
        keep  = keep & BOT_KEEP;
        extra = extra | item_q.bottom_label_byte;
      end
    end
    page_byte_o = (pix & keep) | extra;
  end

endmodule

@@ design/gcr_ctrl.sv @@
// sequencer: accept, scale, divide, commit, then walk the pages
module gcr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              out_last_o,
  output gcr_pkg::gcr_cmd_t cmd_o
);
  import gcr_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PREP   = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_COMMIT = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [SHIFT_W-1:0] step_q, step_d;
  logic [PAGE_W-1:0]  page_q, page_d;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    page_d      = page_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    out_last_o  = 1'b0;
    cmd_o       = '0;
    cmd_o.page  = page_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        step_d     = LAST_SHIFT;
        state_d    = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step  = 1'b1;
        cmd_o.div_shift = step_q;
        if (step_q == '0) begin
          state_d = S_COMMIT;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        page_d       = '0;
        state_d      = S_EMIT;
      end
      S_EMIT: begin
        out_valid_o = 1'b1;
        out_last_o  = (page_q == LAST_PAGE);
        if (out_ready_i) begin
          if (page_q == LAST_PAGE) begin
            state_d = S_IDLE;
          end else begin
            page_d = page_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      page_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      page_q  <= page_d;
    end
  end

endmodule

@@ design/gcr_checker.sv @@
// port-level checks for the graph column rasterizer, bound to the top level
module gcr_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tready_o,
  input logic                        m_axis_tvalid_o,
  input logic                        m_axis_tready_i,
  input logic [gcr_pkg::PAGE_W-1:0]  m_axis_tuser_o,
  input logic                        m_axis_tlast_o,
  input logic                        pready_o
);
  import gcr_pkg::*;

  // one column in flight: no input taken while page bytes are offered
  a_one_column: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input ready while page bytes pending");

  a_last_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |-> (m_axis_tuser_o == LAST_PAGE))
    else $error("tlast on wrong page");

  a_page_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o) |=>
      (m_axis_tvalid_o && (m_axis_tuser_o == PAGE_W'($past(m_axis_tuser_o) + 1'b1))))
    else $error("page sequence broken");

  a_back_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o) |=> s_axis_tready_o)
    else $error("not ready after column end");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready_o)
    else $error("pready low");

endmodule

bind graph_column_rasterizer_top gcr_checker u_gcr_checker (.*);
